/* hw/rtl/wsfr_pkg.sv */
package wsfr_pkg;

  // Width kept for the decoded payload length and the payload countdown.
  localparam int LEN_W = 32;

  // Frame classification codes carried in frame_action.
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_DELIVER  = 3'd1;
  localparam logic [2:0] ACT_FRAGMENT = 3'd2;
  localparam logic [2:0] ACT_CONTROL  = 3'd3;
  localparam logic [2:0] ACT_FAIL     = 3'd4;
  localparam logic [2:0] ACT_DISCARD  = 3'd5;

  // One parsed byte, handed from the front parser to the back end.
  typedef struct packed {
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic             header_valid;
    logic [7:0]       hdr_byte;
    logic [LEN_W-1:0] frame_length;
    logic             frame_end;
  } tok_t;

endpackage

/* hw/rtl/websocket_frame_receiver.sv */
// Receives a masked client-to-server WebSocket byte stream, one byte per
// input beat, and returns exactly one result beat per input beat. The
// front parser walks the header (first byte, 7-bit length, optional 16-bit
// or 64-bit extended length of which the low 32 bits are kept, 4-byte
// masking key) and unmasks payload bytes; a two-entry queue then feeds the
// back end, which classifies each frame on its last beat (deliver,
// fragment, control, protocol fail, or discard of non-close frames on a
// failing connection) and holds the result in an output register. Rate is
// one byte per cycle unless the output stalls; results pass through the
// queue and the output register. A stall on the output side backs up the
// queue and drops in_tready only once both queue entries are full. There
// is no configuration; the failing state is sticky until reset.
module websocket_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] payload_valid, [8:1] payload_byte, [9] header_valid, [10] fin_flag,
  // [14:11] frame_opcode, [46:15] frame_length, [49:47] frame_action,
  // [55:50] zero
  output logic [55:0] out_tdata,
  output logic        out_tlast   // frame_end
);

  wsfr_pkg::tok_t push_tok;
  wsfr_pkg::tok_t pop_tok;
  logic           push;
  logic           pop;
  logic           full;
  logic           not_empty;

  // header parse and payload unmask
  wsfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid),
    .byte_in    (in_tdata),
    .byte_ready (in_tready),
    .tok_push   (push),
    .tok        (push_tok),
    .fifo_full  (full)
  );

  // decouples parser from the output stall
  wsfr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_tok),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_tok)
  );

  // frame classification, fragment/failing flags, output register
  wsfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_avail (not_empty),
    .tok       (pop_tok),
    .tok_pop   (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

/* hw/rtl/wsfr_front.sv */
module wsfr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        byte_in,
  output logic              byte_ready,
  output logic              tok_push,
  output wsfr_pkg::tok_t    tok,
  input  logic              fifo_full
);

  localparam logic [2:0] PH_BYTE0   = 3'd0;
  localparam logic [2:0] PH_BYTE1   = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  localparam int LW = wsfr_pkg::LEN_W;

  logic [2:0]    phase_r, phase_nxt;
  logic [3:0]    hcount_r, hcount_nxt;
  logic [7:0]    fhb_r, fhb_nxt;
  logic          is127_r, is127_nxt;
  logic [LW-1:0] ext_r, ext_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [LW-1:0] rem_r, rem_nxt;
  logic [1:0]    midx_r, midx_nxt;
  logic [7:0]    key_byte;
  logic          accept;

  assign byte_ready = !fifo_full;
  assign accept     = byte_valid && byte_ready;
  assign tok_push   = accept;

  // key byte 0 sits in the top byte of the shifted-in key
  always_comb begin
    unique case (midx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    hcount_nxt = hcount_r;
    fhb_nxt    = fhb_r;
    is127_nxt  = is127_r;
    ext_nxt    = ext_r;
    key_nxt    = key_r;
    rem_nxt    = rem_r;
    midx_nxt   = midx_r;
    tok        = '0;

    unique case (phase_r)
      PH_BYTE1: begin
        hcount_nxt = 4'd2;
        midx_nxt   = 2'd0;
        is127_nxt  = (byte_in[6:0] == 7'd127);
        if (byte_in[6:0] < 7'd126) begin
          ext_nxt   = LW'(byte_in[6:0]);
          phase_nxt = PH_MASK;
        end else begin
          ext_nxt   = '0;
          phase_nxt = PH_EXT;
        end
      end
      PH_EXT: begin
        ext_nxt    = {ext_r[LW-9:0], byte_in};
        hcount_nxt = hcount_r + 4'd1;
        if (hcount_nxt == (is127_r ? 4'd10 : 4'd4)) begin
          phase_nxt = PH_MASK;
        end
      end
      PH_MASK: begin
        key_nxt    = {key_r[23:0], byte_in};
        hcount_nxt = hcount_r + 4'd1;
        midx_nxt   = midx_r + 2'd1;
        if (midx_r == 2'd3) begin
          tok.header_valid = 1'b1;
          tok.frame_length = ext_r;
          rem_nxt          = ext_r;
          if (ext_r == '0) begin
            tok.frame_end = 1'b1;
            phase_nxt     = PH_BYTE0;
            hcount_nxt    = 4'd0;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        tok.payload_valid = 1'b1;
        tok.payload_byte  = byte_in ^ key_byte;
        tok.frame_length  = ext_r;
        midx_nxt          = midx_r + 2'd1;
        rem_nxt           = rem_r - LW'(1);
        if (rem_r == LW'(1)) begin
          tok.frame_end = 1'b1;
          phase_nxt     = PH_BYTE0;
          hcount_nxt    = 4'd0;
        end
      end
      default: begin
        // first header byte (also recovers from unused codes)
        fhb_nxt    = byte_in;
        hcount_nxt = 4'd1;
        midx_nxt   = 2'd0;
        phase_nxt  = PH_BYTE1;
      end
    endcase

    tok.hdr_byte = fhb_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_BYTE0;
      hcount_r <= '0;
      fhb_r    <= '0;
      is127_r  <= 1'b0;
      ext_r    <= '0;
      key_r    <= '0;
      rem_r    <= '0;
      midx_r   <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      hcount_r <= hcount_nxt;
      fhb_r    <= fhb_nxt;
      is127_r  <= is127_nxt;
      ext_r    <= ext_nxt;
      key_r    <= key_nxt;
      rem_r    <= rem_nxt;
      midx_r   <= midx_nxt;
    end
  end

endmodule

/* hw/rtl/wsfr_fifo.sv */
module wsfr_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wsfr_pkg::tok_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output wsfr_pkg::tok_t pop_data
);

  wsfr_pkg::tok_t mem_r [2];
  logic           wptr_r, wptr_nxt;
  logic           rptr_r, rptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* hw/rtl/wsfr_back.sv */
module wsfr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           tok_avail,
  input  wsfr_pkg::tok_t tok,
  output logic           tok_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [55:0]    out_data,
  output logic           out_last
);

  logic           out_valid_r, out_valid_nxt;
  wsfr_pkg::tok_t res_r;
  logic [2:0]     act_r, act_nxt;
  logic           frag_r, frag_nxt;
  logic           failing_r, failing_nxt;
  logic [7:0]     b;
  logic [2:0]     act_cls;

  assign tok_pop = tok_avail && (!out_valid_r || out_ready);
  assign b       = tok.hdr_byte;

  always_comb begin
    priority if (failing_r && b[3:0] != 4'h8) begin
      act_cls = wsfr_pkg::ACT_DISCARD;
    end else if (b == 8'h88 || b == 8'h89 || b == 8'h8a) begin
      act_cls = wsfr_pkg::ACT_CONTROL;
    end else if (frag_r) begin
      act_cls = (b == 8'h80) ? wsfr_pkg::ACT_DELIVER :
                (b == 8'h00) ? wsfr_pkg::ACT_FRAGMENT : wsfr_pkg::ACT_FAIL;
    end else begin
      act_cls = (b == 8'h81 || b == 8'h82) ? wsfr_pkg::ACT_DELIVER :
                (b == 8'h01 || b == 8'h02) ? wsfr_pkg::ACT_FRAGMENT :
                wsfr_pkg::ACT_FAIL;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    act_nxt       = act_r;
    frag_nxt      = frag_r;
    failing_nxt   = failing_r;
    if (tok_pop) begin
      out_valid_nxt = 1'b1;
      act_nxt       = tok.frame_end ? act_cls : wsfr_pkg::ACT_NONE;
      if (tok.frame_end) begin
        if (act_cls == wsfr_pkg::ACT_DELIVER) begin
          frag_nxt = 1'b0;
        end else if (act_cls == wsfr_pkg::ACT_FRAGMENT) begin
          frag_nxt = 1'b1;
        end else if (act_cls == wsfr_pkg::ACT_FAIL) begin
          failing_nxt = 1'b1;
        end
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      res_r <= tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      act_r       <= wsfr_pkg::ACT_NONE;
      frag_r      <= 1'b0;
      failing_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      act_r       <= act_nxt;
      frag_r      <= frag_nxt;
      failing_r   <= failing_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_last  = res_r.frame_end;
  assign out_data  = {6'd0,
                      act_r,
                      32'(res_r.frame_length),
                      res_r.hdr_byte[3:0],
                      res_r.hdr_byte[7],
                      res_r.header_valid,
                      res_r.payload_byte,
                      res_r.payload_valid};

endmodule

/* dv/tb_websocket_frame_receiver.sv */
`timescale 1ns / 1ps

module tb_websocket_frame_receiver;

  // ---------------------------------------------------------------------
  // Clock, reset and DUT hookup
  // ---------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;  // [7:0] data_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [0] payload_valid, [8:1] payload_byte, [9] header_valid, [10] fin_flag,
  // [14:11] frame_opcode, [46:15] frame_length, [49:47] frame_action
  logic [55:0] out_tdata;
  logic        out_tlast;         // frame_end

  always #5 clk = ~clk;

  websocket_frame_receiver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // ---------------------------------------------------------------------
  // Types
  // ---------------------------------------------------------------------
  // Where the parser is within a frame.
  typedef enum logic [2:0] {
    ST_HDR0,    // waiting for FIN/opcode byte
    ST_LEN,     // waiting for mask bit + 7-bit length
    ST_EXTLEN,  // collecting 16- or 64-bit extended length
    ST_KEY,     // collecting 4 masking-key bytes
    ST_DATA     // unmasking payload
  } parse_st_e;

  // How the payload length is encoded on the wire.
  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;

  // One result beat, field by field.
  typedef struct packed {
    logic        pv;     // payload_valid
    logic [7:0]  pb;     // payload_byte
    logic        hv;     // header_valid
    logic        fin;    // fin_flag
    logic [3:0]  opc;    // frame_opcode
    logic [31:0] flen;   // frame_length
    logic        fend;   // frame_end
    logic [2:0]  act;    // frame_action
  } ws_result_t;

  // ---------------------------------------------------------------------
  // Predictor state: mirrors the receiver's parse state
  // ---------------------------------------------------------------------
  parse_st_e   parse_st    = ST_HDR0;
  logic [3:0]  hdr_cnt     = '0;
  logic [7:0]  hdr0        = '0;   // first header byte of current frame
  logic [6:0]  len7        = '0;   // 7-bit length code
  logic [31:0] ext_len     = '0;   // decoded length, low 32 bits only
  logic [31:0] key         = '0;   // masking key, first byte in [31:24]
  logic [31:0] remaining   = '0;
  logic [1:0]  key_idx     = '0;
  logic        frag_active = 1'b0; // a fragmented message is in progress
  logic        conn_fail   = 1'b0; // sticky once a frame fails

  ws_result_t  pending_results[$];

  int unsigned err_cnt  = 0;
  int unsigned sent_cnt = 0;  // accepted input beats
  int unsigned out_cnt  = 0;  // accepted result beats
  bit          calm     = 1'b0; // no idling on either side while set
  bit          gen_frag = 1'b0; // stimulus-side view of fragmentation

  // ---------------------------------------------------------------------
  // Frame classification on the last beat of a frame. Close frames still
  // get classified once the connection is failing; the rest are dropped.
  // ---------------------------------------------------------------------
  function automatic logic [2:0] classify_frame();
    logic [2:0] a;
    if (conn_fail && hdr0[3:0] != 4'h8)
      return wsfr_pkg::ACT_DISCARD;
    if (hdr0 >= 8'h88 && hdr0 <= 8'h8A)
      a = wsfr_pkg::ACT_CONTROL;
    else if (frag_active)
      a = (hdr0 == 8'h80) ? wsfr_pkg::ACT_DELIVER :
          (hdr0 == 8'h00) ? wsfr_pkg::ACT_FRAGMENT : wsfr_pkg::ACT_FAIL;
    else
      a = (hdr0 == 8'h81 || hdr0 == 8'h82) ? wsfr_pkg::ACT_DELIVER :
          (hdr0 == 8'h01 || hdr0 == 8'h02) ? wsfr_pkg::ACT_FRAGMENT :
          wsfr_pkg::ACT_FAIL;
    if (a == wsfr_pkg::ACT_DELIVER)
      frag_active = 1'b0;
    else if (a == wsfr_pkg::ACT_FRAGMENT)
      frag_active = 1'b1;
    else if (a == wsfr_pkg::ACT_FAIL)
      conn_fail = 1'b1;
    return a;
  endfunction

  // Advance the parse state by one received byte and queue the result
  // beat it must produce.
  function automatic void ws_parse_byte(input logic [7:0] b);
    ws_result_t r;
    logic       show_len;
    r        = '0;
    show_len = 1'b0;
    case (parse_st)
      ST_LEN: begin
        len7    = b[6:0];   // MASK bit is ignored
        hdr_cnt = 4'd2;
        key_idx = 2'd0;
        if (b[6:0] < 7'd126) begin
          ext_len  = {25'd0, b[6:0]};
          parse_st = ST_KEY;
        end else begin
          ext_len  = '0;
          parse_st = ST_EXTLEN;
        end
      end
      ST_EXTLEN: begin
        // 64-bit lengths: upper bytes fall off the top
        ext_len = {ext_len[23:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt == ((len7 == 7'd126) ? 4'd4 : 4'd10))
          parse_st = ST_KEY;
      end
      ST_KEY: begin
        key     = {key[23:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        key_idx = key_idx + 2'd1;
        if (key_idx == 2'd0) begin
          r.hv      = 1'b1;
          show_len  = 1'b1;
          remaining = ext_len;
          if (remaining == 32'd0) begin
            // empty payload: header and frame end on the same beat
            r.fend   = 1'b1;
            r.act    = classify_frame();
            parse_st = ST_HDR0;
            hdr_cnt  = 4'd0;
          end else begin
            parse_st = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        r.pv      = 1'b1;
        show_len  = 1'b1;
        r.pb      = b ^ key[8*(3 - int'(key_idx)) +: 8];
        key_idx   = key_idx + 2'd1;
        remaining = remaining - 32'd1;
        if (remaining == 32'd0) begin
          r.fend   = 1'b1;
          r.act    = classify_frame();
          parse_st = ST_HDR0;
          hdr_cnt  = 4'd0;
        end
      end
      default: begin
        hdr0     = b;
        hdr_cnt  = 4'd1;
        key_idx  = 2'd0;
        parse_st = ST_LEN;
      end
    endcase
    r.fin  = hdr0[7];
    r.opc  = hdr0[3:0];
    r.flen = show_len ? ext_len : 32'd0;
    pending_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Mismatch reporting and field compare
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40)
      $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s: got 0x%0h, want 0x%0h",
                                out_cnt, name, got, want));
  endtask

  // ---------------------------------------------------------------------
  // Beat monitor: predicts on every accepted input beat, then checks every
  // accepted result beat against the oldest prediction. Input is handled
  // first so a same-cycle result would still find its prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : beat_monitor
    ws_result_t got;
    ws_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        ws_parse_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        got.pv   = out_tdata[0];
        got.pb   = out_tdata[8:1];
        got.hv   = out_tdata[9];
        got.fin  = out_tdata[10];
        got.opc  = out_tdata[14:11];
        got.flen = out_tdata[46:15];
        got.act  = out_tdata[49:47];
        got.fend = out_tlast;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("beat %0d: result with nothing pending",
                                    out_cnt));
        end else begin
          want = pending_results.pop_front();
          check_field("payload_valid", 32'(got.pv),   32'(want.pv));
          check_field("payload_byte",  32'(got.pb),   32'(want.pb));
          check_field("header_valid",  32'(got.hv),   32'(want.hv));
          check_field("fin_flag",      32'(got.fin),  32'(want.fin));
          check_field("frame_opcode",  32'(got.opc),  32'(want.opc));
          check_field("frame_length",  got.flen,      want.flen);
          check_field("frame_end",     32'(got.fend), 32'(want.fend));
          check_field("frame_action",  32'(got.act),  32'(want.act));
        end
        out_cnt++;
      end
    end
  end

  // Result-side backpressure: ~32% stall cycles unless in a calm stretch.
  always @(posedge clk)
    out_tready <= calm || ($urandom_range(0, 99) >= 32);

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // One input beat. An idle gap of random length precedes ~32% of beats;
  // tvalid is left high on return so back-to-back beats need no toggle.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 32) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_cnt++;
  endtask

  // Whole masked frame: header, optional extended length, key, payload.
  task automatic send_frame(input logic [7:0] first, input logic [31:0] len,
                            input len_form_e form);
    logic [7:0] b1;
    send_byte(first);
    b1[7]   = 1'($urandom_range(0, 1));
    b1[6:0] = (form == LEN_SHORT) ? len[6:0] :
              (form == LEN_EXT16) ? 7'd126 : 7'd127;
    send_byte(b1);
    if (form == LEN_EXT16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (form == LEN_EXT64) begin
      // upper four bytes are dropped by the receiver, so make them noise
      repeat (4) send_byte(8'($urandom_range(0, 255)));
      send_byte(len[31:24]);
      send_byte(len[23:16]);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Random payload size, mostly short; long encodings carry small values
  // (including non-minimal ones) to keep frames cheap.
  task automatic pick_shape(output logic [31:0] len, output len_form_e form);
    int unsigned k;
    k = $urandom_range(0, 19);
    form = LEN_SHORT;
    if (k == 0)
      len = 32'd0;
    else if (k <= 13)
      len = $urandom_range(1, 20);
    else if (k <= 15)
      len = $urandom_range(1, 125);
    else if (k <= 17) begin
      form = LEN_EXT16;
      len  = $urandom_range(0, 300);
    end else if (k == 18) begin
      form = LEN_EXT16;
      len  = $urandom_range(0, 3);
    end else begin
      form = LEN_EXT64;
      len  = $urandom_range(0, 40);
    end
  endtask

  // Stop sending and hold off until every predicted beat has come back.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Empty ping (header_valid and frame_end together), a text fragment with
  // a 16-bit length, then its final continuation with a 64-bit length.
  task automatic test_directed_frames();
    send_frame(8'h89, 32'd0, LEN_SHORT);
    send_frame(8'h01, 32'd2, LEN_EXT16);
    send_frame(8'h80, 32'd1, LEN_EXT64);
    gen_frag = 1'b0;
  endtask

  // Legal traffic only: data frames that follow the fragmentation rules,
  // control frames interleaved. Calm while sent_cnt is in 500..799.
  task automatic test_legal_traffic(input int unsigned until_cnt);
    logic [7:0]  first;
    logic [31:0] len;
    len_form_e   form;
    while (sent_cnt < until_cnt) begin
      calm = (sent_cnt >= 500 && sent_cnt < 800);
      if ($urandom_range(0, 9) < 2) begin
        first = 8'h88 + 8'($urandom_range(0, 2));
      end else if (gen_frag) begin
        first    = $urandom_range(0, 1) ? 8'h80 : 8'h00;
        gen_frag = (first == 8'h00);
      end else begin
        first    = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 6'd0,
                    $urandom_range(0, 1) ? 1'b1 : 1'b0} + 8'h01;
        gen_frag = !first[7];
      end
      pick_shape(len, form);
      send_frame(first, len, form);
    end
    calm = 1'b0;
  endtask

  // Sender pauses with results outstanding, then traffic resumes.
  task automatic test_pause_until_drained();
    wait_drain();
    send_frame(8'h89, 32'd0, LEN_SHORT);
  endtask

  // A frame that breaks the fragmentation rules makes the failure sticky;
  // afterwards any first byte is sent and only close frames get classified.
  task automatic test_protocol_failure(input int unsigned until_cnt);
    logic [7:0]  first;
    logic [31:0] len;
    len_form_e   form;
    send_frame(gen_frag ? 8'h81 : 8'h80, $urandom_range(0, 5), LEN_SHORT);
    while (sent_cnt < until_cnt) begin
      first = ($urandom_range(0, 3) == 0) ? 8'h88 : 8'($urandom_range(0, 255));
      pick_shape(len, form);
      send_frame(first, len, form);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_legal_traffic(900);
    test_pause_until_drained();
    test_legal_traffic(1300);
    test_protocol_failure(1650);

    // let the pipeline empty, then keep watching for stray beats
    wait_drain();
    repeat (20) @(posedge clk);

    if (err_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/wsfr_pkg.sv
hw/rtl/wsfr_front.sv
hw/rtl/wsfr_fifo.sv
hw/rtl/wsfr_back.sv
hw/rtl/websocket_frame_receiver.sv
dv/tb_websocket_frame_receiver.sv
